// ----- hdl/uvf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and byte-class constants for the UTF-8 validating filter.
// No dependencies; every other file in hdl/ imports this package.
package uvf_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 3;
  localparam int unsigned WinDepth = 4;
  localparam int unsigned PendDepth = 3;
  localparam int unsigned OutDataW = 40;

  localparam logic [7:0] NulByte    = 8'h00;
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] TailMask   = 8'hC0;
  localparam logic [7:0] TailTag    = 8'h80;
  localparam logic [7:0] Lead2Min   = 8'hC2;
  localparam logic [7:0] Lead2Max   = 8'hDF;
  localparam logic [7:0] Lead3Min   = 8'hE0;
  localparam logic [7:0] Lead3Max   = 8'hEF;
  localparam logic [7:0] Lead4Min   = 8'hF0;
  localparam logic [7:0] Lead4Max   = 8'hF4;
  localparam logic [7:0] SurrLead   = 8'hED;
  localparam logic [7:0] E0Floor    = 8'hA0;
  localparam logic [7:0] F0Floor    = 8'h90;
  localparam logic [7:0] F4Ceil     = 8'h8F;

  // One result: count of released bytes and the bytes, zero above count.
  typedef struct packed {
    logic [3:0][ByteW-1:0] bytes;
    logic [CountW-1:0]     count;
  } uvf_result_t;

  function automatic logic is_tail(input logic [7:0] b);
    return (b & TailMask) == TailTag;
  endfunction

  // Sequence length of a lead byte, zero for anything that cannot lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= Lead2Min && b <= Lead2Max) len = 3'd2;
    else if (b >= Lead3Min && b <= Lead3Max) len = 3'd3;
    else if (b >= Lead4Min && b <= Lead4Max) len = 3'd4;
    return len;
  endfunction

endpackage

// ----- hdl/uvf_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts raw bytes, holds the pending window and scans it.
// Depends on uvf_pkg; pushes one result per accepted byte into uvf_queue.
module uvf_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               in_byte_i,
  output logic                     push_o,
  output uvf_pkg::uvf_result_t     result_o,
  input  logic                     q_ready_i
);
  import uvf_pkg::*;

  logic [PendDepth-1:0][ByteW-1:0] pend_q, pend_d;
  logic [1:0]                      cnt_q, cnt_d;

  logic [WinDepth-1:0][ByteW-1:0]  win;
  logic [3:0][ByteW-1:0]           rel;
  logic [2:0]                      n, pos, nrel, need;
  logic [7:0]                      b0, b1, b2, b3;
  logic                            stop, ok, accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign push_o     = accept;

  always_comb begin
    win[0] = (cnt_q == 2'd0) ? in_byte_i : pend_q[0];
    win[1] = (cnt_q == 2'd1) ? in_byte_i : pend_q[1];
    win[2] = (cnt_q == 2'd2) ? in_byte_i : pend_q[2];
    win[3] = in_byte_i;
    n      = {1'b0, cnt_q} + 3'd1;
    pos    = 3'd0;
    nrel   = 3'd0;
    rel    = '0;
    stop   = 1'b0;
    need   = 3'd0;
    ok     = 1'b0;
    b0     = '0;
    b1     = '0;
    b2     = '0;
    b3     = '0;
    // At most four scan steps: each step consumes at least one byte or stops.
    for (int s = 0; s < WinDepth; s++) begin
      if (!stop && pos < n) begin
        b0 = win[pos[1:0]];
        b1 = win[pos[1:0] + 2'd1];
        b2 = win[pos[1:0] + 2'd2];
        b3 = win[pos[1:0] + 2'd3];
        if (b0 == NulByte) begin
          pos = pos + 3'd1;
        end else if (b0 < AsciiLimit) begin
          rel[nrel[1:0]] = b0;
          nrel = nrel + 3'd1;
          pos  = pos + 3'd1;
        end else begin
          need = lead_len(b0);
          if (need == 3'd0) begin
            pos = pos + 3'd1;
          end else if (pos + need > n) begin
            // hold the incomplete sequence for the next byte
            stop = 1'b1;
          end else begin
            case (need)
              3'd2: ok = is_tail(b1);
              3'd3: ok = is_tail(b1) && is_tail(b2)
                         && !(b0 == Lead3Min && b1 < E0Floor)
                         && !(b0 == SurrLead && b1 >= E0Floor);
              3'd4: ok = is_tail(b1) && is_tail(b2) && is_tail(b3)
                         && !(b0 == Lead4Min && b1 < F0Floor)
                         && !(b0 == Lead4Max && b1 > F4Ceil);
              default: ok = 1'b0;
            endcase
            if (ok) begin
              for (int k = 0; k < WinDepth; k++) begin
                if (3'(k) < need) begin
                  rel[nrel[1:0] + 2'(k)] = win[pos[1:0] + 2'(k)];
                end
              end
              nrel = nrel + need;
              pos  = pos + need;
            end else begin
              // drop only the lead and rescan what follows
              pos = pos + 3'd1;
            end
          end
        end
      end
    end
    for (int k = 0; k < PendDepth; k++) begin
      pend_d[k] = win[pos[1:0] + 2'(k)];
    end
    cnt_d = 2'(n - pos);
  end

  assign result_o.count = nrel;
  assign result_o.bytes = rel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
  end

endmodule

// ----- hdl/uvf_queue.sv -----
`timescale 1ns / 1ps
// Two-entry result queue between the scanner and the output stage.
// Depends on uvf_pkg for the result type.
module uvf_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  uvf_pkg::uvf_result_t push_data_i,
  output logic                 ready_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output uvf_pkg::uvf_result_t pop_data_o
);
  import uvf_pkg::*;

  uvf_result_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fill_q;
  logic        do_push, do_pop;

  assign ready_o    = fill_q != 2'd2;
  assign valid_o    = fill_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) fill_q <= fill_q + 2'd1;
      else if (do_pop && !do_push) fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/uvf_back.sv -----
`timescale 1ns / 1ps
// Back end: output register that packs a result onto the master stream.
// Depends on uvf_pkg; drains uvf_queue.
module uvf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  uvf_pkg::uvf_result_t          q_data_i,
  output logic                          q_pop_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [uvf_pkg::OutDataW-1:0]  m_data_o
);
  import uvf_pkg::*;

  localparam int unsigned ResW = $bits(uvf_result_t);

  logic                valid_q;
  logic [OutDataW-1:0] data_q;
  logic                load;

  // advance when the register is empty or its request is being taken
  assign load    = q_valid_i && (!valid_q || m_ready_i);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= {{(OutDataW - ResW){1'b0}}, q_data_i};
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule

// ----- hdl/utf8_validating_filter_core.sv -----
`timescale 1ns / 1ps
// Top level of the UTF-8 validating filter: scanner, result queue, output stage.
// Depends on uvf_pkg, uvf_front, uvf_queue and uvf_back.
//
//  channel   dir  width  contents (lowest bit first)
//  s_axis    in   8      in_byte
//  m_axis    out  40     out_count[2:0], out_byte0..out_byte3, 5 zero bits
//
// While the queue has room, one byte is accepted per cycle; the pending window
// (up to three held bytes plus the new one) is scanned as the byte is accepted.
// A result is written into the queue and then into the output register before
// it appears on m_axis.
// Reset clears the pending count, the queue and the output valid; held bytes are
// left as they are. A stalled output fills the two-entry queue, then drops
// s_axis_tready_o.
module utf8_validating_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] out_count, [10:3] out_byte0, [18:11] out_byte1, [26:19] out_byte2,
  // [34:27] out_byte3, [39:35] zero
  output logic [39:0] m_axis_tdata_o
);
  import uvf_pkg::*;

  uvf_result_t front_res, q_res;
  logic        push, q_ready, q_valid, q_pop;

  uvf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .push_o     (push),
    .result_o   (front_res),
    .q_ready_i  (q_ready)
  );

  uvf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_res),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_res)
  );

  uvf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_res),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

endmodule
